// ===== hw/rtl/atce_pkg.sv =====
// ----------------------------------------------------------------------------
// atce_pkg: shared definitions for the ANSI text console engine
// Screen geometry, byte codes, parser phases, queued operations, palette.
// ----------------------------------------------------------------------------
package atce_pkg;

   // screen geometry and parser depth
   localparam int COLS       = 80;
   localparam int ROWS       = 30;
   localparam int MAX_PARAMS = 4;

   // widths fixed by the result fields
   localparam int COL_W   = 7;
   localparam int ROW_W   = 6;
   localparam int PIDX_W  = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

   // op queue between front and back (depth a power of two)
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   // byte codes
   localparam logic [7:0] CH_ESC    = 8'h1B;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_DEL    = 8'h7F;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_SGR    = 8'h6D;   // 'm'
   localparam logic [7:0] CH_ED     = 8'h4A;   // 'J'
   localparam logic [7:0] CH_CUP    = 8'h48;   // 'H'
   localparam logic [7:0] CH_EL     = 8'h4B;   // 'K'

   localparam logic [31:0] WHITE     = 32'hFFFF_FFFF;
   localparam logic [15:0] SGR_RESET = 16'd0;
   localparam logic [15:0] SGR_FG_LO = 16'd30;
   localparam logic [15:0] SGR_FG_HI = 16'd37;
   localparam logic [15:0] PARAM_SAT = 16'hFFFF;

   typedef enum logic [1:0] {
      PH_TEXT,
      PH_ESC,
      PH_CSI
   } phase_type;

   typedef enum logic [2:0] {
      OP_TEXT,
      OP_CR,
      OP_LF,
      OP_BS,
      OP_CLEAR,
      OP_HOME,
      OP_EOL
   } op_kind_type;

   typedef enum logic [1:0] {
      CMD_DRAW,
      CMD_SCROLL,
      CMD_CLEAR,
      CMD_EOL
   } cmd_type;

   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  glyph;
      logic [31:0] color;
   } op_type;

   // eight-colour palette, 0xAARRGGBB
   function automatic logic [31:0] palette_lookup(input logic [2:0] idx);
      logic [31:0] c;
      unique case (idx)
         3'd0: c = 32'hFF00_0000;
         3'd1: c = 32'hFFFF_0000;
         3'd2: c = 32'hFF00_FF00;
         3'd3: c = 32'hFFFF_FF00;
         3'd4: c = 32'hFF00_00FF;
         3'd5: c = 32'hFFFF_00FF;
         3'd6: c = 32'hFF00_FFFF;
         3'd7: c = 32'hFFFF_FFFF;
         default: c = WHITE;
      endcase
      return c;
   endfunction

endpackage

// ===== hw/rtl/atce_queue.sv =====
// ----------------------------------------------------------------------------
// atce_queue: op queue between parser front and cursor back
// Small register FIFO; push and pop may coincide.
// ----------------------------------------------------------------------------
module atce_queue import atce_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   input  logic   pop,
   output op_type head_op,
   output logic   empty,
   output logic   full
);

   op_type              mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == QCNT_W'(QDEPTH));
   assign head_op = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ===== hw/rtl/atce_front.sv =====
// ----------------------------------------------------------------------------
// atce_front: byte parser
// Runs the escape parser and colour state, turns bytes into cursor ops.
// ----------------------------------------------------------------------------
module atce_front import atce_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_valid,
   input  logic [7:0] byte_in,
   output logic       byte_ready,
   input  logic       q_full,
   output logic       q_push,
   output op_type     q_op
);

   phase_type          phase_ff, phase_in;
   logic [PIDX_W-1:0]  pcount_ff, pcount_in;
   logic [15:0]        params_ff [MAX_PARAMS];
   logic [15:0]        params_in [MAX_PARAMS];
   logic [31:0]        fg_ff, fg_in;

   logic               accept;
   logic               is_digit;
   logic [15:0]        cur_param;
   logic [19:0]        acc;
   logic [15:0]        acc_sat;
   logic [31:0]        sgr_color;
   logic [15:0]        p;

   assign byte_ready = !q_full;
   assign accept     = byte_valid && !q_full;
   assign is_digit   = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
   assign cur_param  = params_ff[pcount_ff];

   // p*10 + digit, saturating
   assign acc     = {1'b0, cur_param, 3'b000} + {3'b000, cur_param, 1'b0}
                    + {16'd0, byte_in[3:0]};
   assign acc_sat = (acc > 20'({PARAM_SAT})) ? PARAM_SAT : acc[15:0];

   // SGR: parameters applied in order, last match wins
   always_comb begin
      sgr_color = fg_ff;
      p         = '0;
      for (int i = 0; i < MAX_PARAMS; i++) begin
         p = params_ff[i];
         if (i <= int'(pcount_ff)) begin
            if (p == SGR_RESET) begin
               sgr_color = WHITE;
            end else if (p >= SGR_FG_LO && p <= SGR_FG_HI) begin
               sgr_color = palette_lookup(3'(p - SGR_FG_LO));
            end
         end
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      pcount_in = pcount_ff;
      params_in = params_ff;
      fg_in     = fg_ff;
      q_push    = 1'b0;
      q_op      = '{kind: OP_TEXT, glyph: byte_in, color: fg_ff};
      if (accept) begin
         unique case (phase_ff)
            PH_ESC: begin
               if (byte_in == CH_LBRACK) begin
                  phase_in  = PH_CSI;
                  pcount_in = '0;
                  for (int i = 0; i < MAX_PARAMS; i++) params_in[i] = '0;
               end else begin
                  phase_in = PH_TEXT;
               end
            end
            PH_CSI: begin
               if (is_digit) begin
                  params_in[pcount_ff] = acc_sat;
               end else if (byte_in == CH_SEMI) begin
                  if (int'(pcount_ff) < MAX_PARAMS - 1) begin
                     pcount_in            = pcount_ff + PIDX_W'(1);
                     params_in[pcount_in] = '0;
                  end
               end else begin
                  phase_in = PH_TEXT;
                  priority if (byte_in == CH_SGR) begin
                     fg_in = sgr_color;
                  end else if (byte_in == CH_ED) begin
                     q_push    = 1'b1;
                     q_op.kind = OP_CLEAR;
                  end else if (byte_in == CH_CUP) begin
                     q_push    = 1'b1;
                     q_op.kind = OP_HOME;
                  end else if (byte_in == CH_EL) begin
                     q_push    = 1'b1;
                     q_op.kind = OP_EOL;
                  end else begin
                     // unknown final byte: swallowed
                  end
               end
            end
            default: begin
               // normal text (also the unused phase code)
               phase_in = PH_TEXT;
               priority if (byte_in == CH_ESC) begin
                  phase_in = PH_ESC;
               end else if (byte_in == CH_CR) begin
                  q_push    = 1'b1;
                  q_op.kind = OP_CR;
               end else if (byte_in == CH_LF) begin
                  q_push    = 1'b1;
                  q_op.kind = OP_LF;
               end else if (byte_in == CH_BS || byte_in == CH_DEL) begin
                  q_push    = 1'b1;
                  q_op.kind = OP_BS;
               end else begin
                  q_push = 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TEXT;
         pcount_ff <= '0;
         fg_ff     <= WHITE;
         for (int i = 0; i < MAX_PARAMS; i++) params_ff[i] <= '0;
      end else begin
         phase_ff  <= phase_in;
         pcount_ff <= pcount_in;
         fg_ff     <= fg_in;
         params_ff <= params_in;
      end
   end

endmodule

// ===== hw/rtl/atce_back.sv =====
// ----------------------------------------------------------------------------
// atce_back: cursor engine and result register
// Executes queued ops against the cursor, emits console commands.
// ----------------------------------------------------------------------------
module atce_back import atce_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  op_type      q_head,
   output logic        q_pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast
);

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             pend_ff, pend_in;     // scroll owed after a wrapping draw

   logic             rsp_valid_ff, rsp_valid_in;
   cmd_type          cmd_ff, cmd_in;
   logic [COL_W-1:0] rcol_ff, rcol_in;
   logic [ROW_W-1:0] rrow_ff, rrow_in;
   logic [7:0]       glyph_ff, glyph_in;
   logic [31:0]      color_ff, color_in;
   logic             last_ff, last_in;

   logic             slot_free;
   logic             load;
   logic             at_end_col;
   logic             at_last_row;

   assign slot_free   = !rsp_valid_ff || rsp_tready;
   assign at_end_col  = (col_ff == COL_W'(COLS - 1));
   assign at_last_row = (row_ff == ROW_W'(ROWS - 1));

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      pend_in  = pend_ff;
      q_pop    = 1'b0;
      load     = 1'b0;
      cmd_in   = CMD_SCROLL;
      rcol_in  = '0;
      rrow_in  = ROW_W'(ROWS - 1);
      glyph_in = '0;
      color_in = '0;
      last_in  = 1'b1;
      if (pend_ff) begin
         if (slot_free) begin
            load    = 1'b1;
            pend_in = 1'b0;
         end
      end else if (!q_empty) begin
         unique case (q_head.kind)
            OP_TEXT: begin
               if (slot_free) begin
                  load     = 1'b1;
                  q_pop    = 1'b1;
                  cmd_in   = CMD_DRAW;
                  rcol_in  = col_ff;
                  rrow_in  = row_ff;
                  glyph_in = q_head.glyph;
                  color_in = q_head.color;
                  last_in  = !(at_end_col && at_last_row);
                  if (at_end_col) begin
                     col_in = '0;
                     if (at_last_row) begin
                        pend_in = 1'b1;
                     end else begin
                        row_in = row_ff + ROW_W'(1);
                     end
                  end else begin
                     col_in = col_ff + COL_W'(1);
                  end
               end
            end
            OP_LF: begin
               if (!at_last_row) begin
                  q_pop  = 1'b1;
                  col_in = '0;
                  row_in = row_ff + ROW_W'(1);
               end else if (slot_free) begin
                  q_pop  = 1'b1;
                  load   = 1'b1;
                  col_in = '0;
               end
            end
            OP_CR: begin
               q_pop  = 1'b1;
               col_in = '0;
            end
            OP_BS: begin
               q_pop = 1'b1;
               if (col_ff != '0) col_in = col_ff - COL_W'(1);
            end
            OP_HOME: begin
               q_pop  = 1'b1;
               col_in = '0;
               row_in = '0;
            end
            OP_CLEAR: begin
               if (slot_free) begin
                  q_pop   = 1'b1;
                  load    = 1'b1;
                  cmd_in  = CMD_CLEAR;
                  rrow_in = '0;
                  col_in  = '0;
                  row_in  = '0;
               end
            end
            OP_EOL: begin
               if (slot_free) begin
                  q_pop   = 1'b1;
                  load    = 1'b1;
                  cmd_in  = CMD_EOL;
                  rcol_in = col_ff;
                  rrow_in = row_ff;
               end
            end
            default: begin
               q_pop = 1'b1;
            end
         endcase
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cmd_ff   <= cmd_in;
         rcol_ff  <= rcol_in;
         rrow_ff  <= rrow_in;
         glyph_ff <= glyph_in;
         color_ff <= color_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = cmd_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {3'b000, color_ff, glyph_ff, rrow_ff, rcol_ff};

   // cursor never leaves the screen
   a_cursor_bounds: assert property (@(posedge clock) disable iff (reset)
      (int'(col_ff) < COLS) && (int'(row_ff) < ROWS))
      else $error("cursor outside screen");

   // an owed scroll only follows a wrap on the bottom row
   a_pend_home: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (col_ff == '0) && (row_ff == ROW_W'(ROWS - 1)))
      else $error("scroll owed with cursor off bottom-left");

   // no op leaves the queue while a scroll is still owed
   a_pend_blocks: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !q_pop)
      else $error("op popped ahead of owed scroll");

   // a wrapping draw on the bottom row is not marked last
   a_wrap_last: assert property (@(posedge clock) disable iff (reset)
      $rose(pend_ff) |-> rsp_valid_ff && !last_ff && (cmd_ff == CMD_DRAW))
      else $error("wrapping draw flagged last");

endmodule

// ===== hw/rtl/ansi_text_console_engine_top.sv =====
// ----------------------------------------------------------------------------
// ansi_text_console_engine_top: byte-stream text console with ANSI subset
// Parser front, op queue, cursor back; emits draw/scroll/clear/EOL commands.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake              payload
//  -------  ---  ---------------------  ---------------------------------------
//  req      in   req_tvalid/req_tready  tdata[7:0] byte_in
//  rsp      out  rsp_tvalid/rsp_tready  tdata col/row/glyph/color, tuser
//                                       command, tlast = last of the request
//
//  A request is taken every cycle while the op queue has room; the front
//  decodes it in the cycle it is accepted.
//  The back retires one op a cycle unless a scroll is owed or its result
//  waits on the result register; a draw that wraps on the bottom row gives
//  a draw, then a scroll, through the single result register. A first
//  result passes the queue entry and then the result register.
//  Reset: cursor home, colour white, parser in normal text, queue empty.
//  A stalled rsp fills the queue, after which req_tready drops.
//
module ansi_text_console_engine_top import atce_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] byte_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,    // [6:0] cell_col, [12:7] cell_row,
                                     // [20:13] glyph, [52:21] color, rest 0
   output logic [1:0]  rsp_tuser,    // [1:0] command
   output logic        rsp_tlast     // last result of the request
);

   logic   q_push;
   logic   q_pop;
   logic   q_empty;
   logic   q_full;
   op_type push_op;
   op_type head_op;

   // parser: escape state, CSI parameters, foreground colour
   atce_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_tvalid),
      .byte_in    (req_tdata),
      .byte_ready (req_tready),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_op       (push_op)
   );

   // decouples parser from cursor engine
   atce_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (push_op),
      .pop     (q_pop),
      .head_op (head_op),
      .empty   (q_empty),
      .full    (q_full)
   );

   // cursor, wrap/scroll and the result register
   atce_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (head_op),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
